// File: rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define B64D_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define B64D_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define B64D_ASSERT(lbl, clk, rst_n, prop, msg)

`define B64D_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// File: rtl/b64d_pkg.sv
`default_nettype none

package b64d_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int ITEM_DEPTH_DEF = 4;
    localparam int RES_DEPTH_DEF  = 2;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int LIMIT_W     = 16;
    localparam int TOTAL_W     = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_URL_ALPHABET = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_LIMIT = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_BAD_CHAR = 2'd1,
        ERR_OVERFLOW = 2'd2
    } t_err;

    // Classified character
    typedef struct packed {
        logic [5:0] sym;
        logic       is_pad;
        logic       is_bad;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [7:0]         data_byte;
        logic               byte_present;
        logic               run_end;
        t_err               error_code;
        logic [TOTAL_W-1:0] byte_total;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/b64d_fifo.sv
`default_nettype none

// DEPTH must be a power of two.
module b64d_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == FULL_COUNT);
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = wr_en ? AW'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = rd_en ? AW'(r_rd_ptr + 1'b1) : r_rd_ptr;
        case ({wr_en, rd_en})
            2'b10:   n_count = CW'(r_count + 1'b1);
            2'b01:   n_count = CW'(r_count - 1'b1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// File: rtl/b64d_front.sv
`default_nettype none

module b64d_front (
    input  logic           i_url_alphabet,
    input  logic           i_push,
    input  logic [7:0]     i_text_char,
    input  logic           i_end_of_text,
    input  logic           i_q_full,
    output logic           o_full,
    output logic           o_q_wr,
    output b64d_pkg::t_item o_item
);
    import b64d_pkg::*;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    assign o_full = i_q_full;
    assign o_q_wr = i_push && !i_q_full;

    always_comb begin
        o_item        = '0;
        o_item.last   = i_end_of_text;
        if (i_text_char >= 8'h41 && i_text_char <= 8'h5A) begin
            o_item.sym = 6'(i_text_char - 8'h41);
        end else if (i_text_char >= 8'h61 && i_text_char <= 8'h7A) begin
            o_item.sym = 6'(i_text_char - 8'h61 + 8'd26);
        end else if (i_text_char >= 8'h30 && i_text_char <= 8'h39) begin
            o_item.sym = 6'(i_text_char - 8'h30 + 8'd52);
        end else if (i_text_char == PAD_CHAR) begin
            o_item.is_pad = 1'b1;
        end else if (i_url_alphabet && i_text_char == 8'h2D) begin
            o_item.sym = 6'd62;
        end else if (i_url_alphabet && i_text_char == 8'h5F) begin
            o_item.sym = 6'd63;
        end else if (!i_url_alphabet && i_text_char == 8'h2B) begin
            o_item.sym = 6'd62;
        end else if (!i_url_alphabet && i_text_char == 8'h2F) begin
            o_item.sym = 6'd63;
        end else begin
            o_item.is_bad = 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/b64d_back.sv
`default_nettype none
`include "assert_macros.svh"

module b64d_back #(
    parameter int COUNT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [b64d_pkg::LIMIT_W-1:0]      i_output_limit,
    input  b64d_pkg::t_item                   i_item,
    input  logic                              i_item_valid,
    output logic                              o_item_pop,
    input  logic                              i_res_full,
    output logic                              o_res_wr,
    output b64d_pkg::t_result                 o_res
);
    import b64d_pkg::*;

    localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

    logic [11:0]           r_acc, n_acc;
    logic [2:0]            r_held, n_held;
    logic                  r_pad, n_pad;
    logic [COUNT_BITS-1:0] r_bytes, n_bytes;
    logic                  r_discard, n_discard;
    logic                  r_second, n_second;

    logic        go;
    logic        do_clear;
    logic [11:0] acc_new;
    logic [3:0]  held_sum;
    logic        has_byte;
    logic [2:0]  held_new;
    logic [7:0]  byte_val;
    logic        over;

    assign go       = i_item_valid && !i_res_full;
    assign acc_new  = {r_acc[5:0], i_item.sym};
    assign held_sum = {1'b0, r_held} + 4'd6;
    assign has_byte = held_sum[3];
    assign held_new = has_byte ? 3'(held_sum - 4'd8) : held_sum[2:0];
    assign over     = (CMP_W'(r_bytes) >= CMP_W'(i_output_limit)) || (&r_bytes);

    always_comb begin
        case (held_new)
            3'd2:    byte_val = acc_new[9:2];
            3'd4:    byte_val = acc_new[11:4];
            default: byte_val = acc_new[7:0];
        endcase
    end

    always_comb begin
        n_acc      = r_acc;
        n_held     = r_held;
        n_pad      = r_pad;
        n_bytes    = r_bytes;
        n_discard  = r_discard;
        n_second   = r_second;
        do_clear   = 1'b0;
        o_item_pop = 1'b0;
        o_res_wr   = 1'b0;
        o_res      = '0;
        o_res.error_code = ERR_NONE;
        o_res.byte_total = TOTAL_W'(r_bytes);

        if (go) begin
            if (r_second) begin
                // closing request of a message whose last char gave a byte
                o_res_wr      = 1'b1;
                o_res.run_end = 1'b1;
                do_clear      = 1'b1;
                n_second      = 1'b0;
                o_item_pop    = 1'b1;
            end else if (r_discard) begin
                o_item_pop = 1'b1;
                if (i_item.last) begin
                    n_discard = 1'b0;
                    do_clear  = 1'b1;
                end
            end else if (i_item.is_pad) begin
                n_pad      = 1'b1;
                o_item_pop = 1'b1;
                if (i_item.last) begin
                    o_res_wr      = 1'b1;
                    o_res.run_end = 1'b1;
                    do_clear      = 1'b1;
                end
            end else if (i_item.is_bad || r_pad) begin
                o_res_wr         = 1'b1;
                o_res.run_end    = 1'b1;
                o_res.error_code = ERR_BAD_CHAR;
                do_clear         = 1'b1;
                n_discard        = !i_item.last;
                o_item_pop       = 1'b1;
            end else if (has_byte && over) begin
                o_res_wr         = 1'b1;
                o_res.run_end    = 1'b1;
                o_res.error_code = ERR_OVERFLOW;
                do_clear         = 1'b1;
                n_discard        = !i_item.last;
                o_item_pop       = 1'b1;
            end else begin
                n_acc  = acc_new;
                n_held = held_new;
                if (has_byte) begin
                    o_res_wr           = 1'b1;
                    o_res.data_byte    = byte_val;
                    o_res.byte_present = 1'b1;
                    o_res.byte_total   = '0;
                    n_bytes            = COUNT_BITS'(r_bytes + 1'b1);
                    if (i_item.last) begin
                        n_second = 1'b1;
                    end else begin
                        o_item_pop = 1'b1;
                    end
                end else begin
                    o_item_pop = 1'b1;
                    if (i_item.last) begin
                        o_res_wr      = 1'b1;
                        o_res.run_end = 1'b1;
                        do_clear      = 1'b1;
                    end
                end
            end
        end

        if (do_clear) begin
            n_acc   = '0;
            n_held  = '0;
            n_pad   = 1'b0;
            n_bytes = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_held    <= '0;
            r_pad     <= 1'b0;
            r_bytes   <= '0;
            r_discard <= 1'b0;
            r_second  <= 1'b0;
        end else begin
            r_acc     <= n_acc;
            r_held    <= n_held;
            r_pad     <= n_pad;
            r_bytes   <= n_bytes;
            r_discard <= n_discard;
            r_second  <= n_second;
        end
    end

    `B64D_ASSERT(a_second_holds_item, i_clk, i_rst_n, r_second |-> i_item_valid, "closing request lost its item")
    `B64D_NEVER(a_second_not_discard, i_clk, i_rst_n, r_second && r_discard, "closing request while discarding")
    `B64D_NEVER(a_held_even, i_clk, i_rst_n, r_held[0], "odd bit count held")
    `B64D_ASSERT(a_byte_counts, i_clk, i_rst_n, (o_res_wr && o_res.byte_present) |=> (r_bytes == COUNT_BITS'($past(r_bytes) + 1'b1)), "byte count did not advance")

endmodule

`default_nettype wire

// File: rtl/base64_stream_decoder.sv
// Base64 stream decoder. Takes one character per clock on the push/full side
// while not full, and returns decoded bytes plus one closing request per message
// on the pop/empty side. Characters are classified on entry and wait in an
// ITEM_DEPTH-deep queue; the decode engine retires one character per cycle while
// the result queue has room, except a message's last character when it also
// completes a byte: that one stays queued until it has yielded the byte and then
// the closing request, as the result queue takes one request per cycle. Results
// sit in a RES_DEPTH-deep queue. Configuration writes are always ready.
`default_nettype none

module base64_stream_decoder #(
    parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEF,
    parameter int ITEM_DEPTH = b64d_pkg::ITEM_DEPTH_DEF,
    parameter int RES_DEPTH  = b64d_pkg::RES_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [b64d_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [b64d_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic [7:0]                        i_text_char,
    input  logic                              i_end_of_text,
    output logic                              o_empty,
    input  logic                              i_pop,
    output logic [7:0]                        o_data_byte,
    output logic                              o_byte_present,
    output logic                              o_run_end,
    output logic [1:0]                        o_error_code,
    output logic [b64d_pkg::TOTAL_W-1:0]      o_byte_total
);
    import b64d_pkg::*;

    logic               r_url;
    logic [LIMIT_W-1:0] r_limit;

    t_item   fr_item, q_item;
    logic    q_wr, q_full, q_empty, q_pop;
    t_result bk_res, out_res;
    logic    res_wr, res_full;
    logic [$bits(t_item)-1:0]   q_rdata;
    logic [$bits(t_result)-1:0] res_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_url   <= 1'b0;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_URL_ALPHABET: r_url   <= i_cfg_data[0];
                CFG_OUTPUT_LIMIT: r_limit <= LIMIT_W'(i_cfg_data);
                default:          r_url   <= r_url;
            endcase
        end
    end

    b64d_front u_front (
        .i_url_alphabet (r_url),
        .i_push         (i_push),
        .i_text_char    (i_text_char),
        .i_end_of_text  (i_end_of_text),
        .i_q_full       (q_full),
        .o_full         (o_full),
        .o_q_wr         (q_wr),
        .o_item         (fr_item)
    );

    b64d_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (ITEM_DEPTH)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (fr_item),
        .o_full  (q_full),
        .i_rd    (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign q_item = t_item'(q_rdata);

    b64d_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_output_limit (r_limit),
        .i_item         (q_item),
        .i_item_valid   (!q_empty),
        .o_item_pop     (q_pop),
        .i_res_full     (res_full),
        .o_res_wr       (res_wr),
        .o_res          (bk_res)
    );

    b64d_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_wdata (bk_res),
        .o_full  (res_full),
        .i_rd    (i_pop),
        .o_rdata (res_rdata),
        .o_empty (o_empty)
    );

    assign out_res        = t_result'(res_rdata);
    assign o_data_byte    = out_res.data_byte;
    assign o_byte_present = out_res.byte_present;
    assign o_run_end      = out_res.run_end;
    assign o_error_code   = out_res.error_code;
    assign o_byte_total   = out_res.byte_total;

endmodule

`default_nettype wire

// File: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::*;

    localparam logic [7:0] PAD_CHAR  = "=";
    localparam logic [6:0] NO_SYM    = 7'd64;
    localparam int         SETTLE    = 16;
    localparam int         LONG_HOLD = 400;
    localparam int         PHASE_CHARS = 180;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } t_char;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   push      = 1'b0;
    logic [7:0]             drv_char  = '0;
    logic                   drv_eot   = 1'b0;
    logic                   pop       = 1'b0;

    logic               o_cfg_ready;
    logic               o_full;
    logic               o_empty;
    logic [7:0]         o_data_byte;
    logic               o_byte_present;
    logic               o_run_end;
    logic [1:0]         o_error_code;
    logic [TOTAL_W-1:0] o_byte_total;

    always #5 clk = ~clk;

    base64_stream_decoder u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_push         (push),
        .o_full         (o_full),
        .i_text_char    (drv_char),
        .i_end_of_text  (drv_eot),
        .o_empty        (o_empty),
        .i_pop          (pop),
        .o_data_byte    (o_data_byte),
        .o_byte_present (o_byte_present),
        .o_run_end      (o_run_end),
        .o_error_code   (o_error_code),
        .o_byte_total   (o_byte_total)
    );

    // Decoder state as the testbench sees it
    logic               url_sel   = 1'b0;
    logic [LIMIT_W-1:0] out_limit = LIMIT_RESET;
    logic [11:0]        acc       = '0;
    logic [3:0]         held      = '0;
    logic               pad_seen  = 1'b0;
    logic [15:0]        bytes_out = '0;
    logic               discarding = 1'b0;

    t_char   char_q[$];
    t_result decoded_q[$];
    t_result want;

    int n_queued  = 0;
    int n_chars   = 0;
    int n_results = 0;
    int n_errors  = 0;
    int n_msgs    = 0;
    int n_bad     = 0;
    int n_ovf     = 0;
    int tx_gap    = 0;
    int tx_calm   = 0;
    int rx_stall  = 0;
    int rx_calm   = 0;

    task automatic report_mismatch(string msg);
        if (n_errors < 100)
            $display("%0t mismatch: %s", $time, msg);
        n_errors++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %0h want %0h (result %0d)",
                                      name, got, exp_val, n_results));
    endtask

    function automatic logic [6:0] sym_value(logic [7:0] c);
        if (c >= "A" && c <= "Z") return 7'(c - "A");
        if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
        if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
        if (url_sel) begin
            if (c == "-") return 7'd62;
            if (c == "_") return 7'd63;
        end else begin
            if (c == "+") return 7'd62;
            if (c == "/") return 7'd63;
        end
        return NO_SYM;
    endfunction

    function automatic void clear_state();
        acc       = '0;
        held      = '0;
        pad_seen  = 1'b0;
        bytes_out = '0;
    endfunction

    function automatic void close_message(t_err err, logic last);
        t_result r;
        r            = '0;
        r.run_end    = 1'b1;
        r.error_code = err;
        r.byte_total = bytes_out;
        decoded_q.push_back(r);
        clear_state();
        discarding = (err != ERR_NONE) && !last;
        n_msgs++;
        if (err == ERR_BAD_CHAR) n_bad++;
        else if (err == ERR_OVERFLOW) n_ovf++;
    endfunction

    function automatic void decode_char(logic [7:0] c, logic last);
        logic [6:0] v;
        t_result    r;
        if (discarding) begin
            if (last) begin
                discarding = 1'b0;
                clear_state();
            end
            return;
        end
        if (c == PAD_CHAR) begin
            pad_seen = 1'b1;
            if (last) close_message(ERR_NONE, 1'b1);
            return;
        end
        v = pad_seen ? NO_SYM : sym_value(c);
        if (v == NO_SYM) begin
            close_message(ERR_BAD_CHAR, last);
            return;
        end
        acc  = {acc[5:0], v[5:0]};
        held = held + 4'd6;
        if (held >= 4'd8) begin
            held = held - 4'd8;
            if (bytes_out >= out_limit || bytes_out == 16'hFFFF) begin
                close_message(ERR_OVERFLOW, last);
                return;
            end
            r              = '0;
            r.byte_present = 1'b1;
            r.data_byte    = 8'(acc >> held);
            decoded_q.push_back(r);
            bytes_out++;
        end
        if (last) close_message(ERR_NONE, 1'b1);
    endfunction

    // mostly short gaps, a few long ones, and stretches with none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] sym_char(logic [5:0] v, logic url);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        if (v == 62) return url ? "-" : "+";
        return url ? "_" : "/";
    endfunction

    function automatic void add_char(logic [7:0] c, logic eot);
        t_char t;
        t.ch  = c;
        t.eot = eot;
        char_q.push_back(t);
        n_queued++;
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i], i == s.len() - 1);
    endfunction

    function automatic void add_message(logic url);
        logic [7:0] msg[$];
        logic [7:0] odd_chars[4];
        int len, npad, kind;
        odd_chars = '{"+", "/", "-", "_"};
        kind = $urandom_range(0, 99);
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 16);
        npad = $urandom_range(0, 2);
        for (int i = 0; i < len; i++)
            msg.push_back(sym_char(6'($urandom_range(0, 63)), url));
        if (kind >= 70 && kind < 85 && len > 0) begin
            // stray byte: one of the four extra symbols of both alphabets, or any byte
            if ($urandom_range(0, 1))
                msg[$urandom_range(0, len - 1)] = odd_chars[$urandom_range(0, 3)];
            else
                msg[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
        end else if (kind >= 95) begin
            foreach (msg[i]) msg[i] = 8'($urandom_range(0, 255));
        end
        if (kind >= 85 && kind < 95 && npad == 0) npad = 1;
        if (len == 0 && npad == 0) npad = 1;
        repeat (npad) msg.push_back(PAD_CHAR);
        if (kind >= 85 && kind < 95) begin
            // symbol after padding
            msg.push_back(sym_char(6'($urandom_range(0, 63)), url));
            if ($urandom_range(0, 1)) msg.push_back(sym_char(6'($urandom_range(0, 63)), url));
        end
        foreach (msg[i])
            add_char(msg[i], i == msg.size() - 1);
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_URL_ALPHABET) url_sel = val[0];
        else out_limit = val;
    endtask

    task automatic set_mode(logic url, logic [LIMIT_W-1:0] lim);
        write_reg(CFG_URL_ALPHABET, {15'($urandom), url});
        write_reg(CFG_OUTPUT_LIMIT, lim);
    endtask

    task automatic drain();
        do @(negedge clk); while (char_q.size() != 0 || push || decoded_q.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    // request sender
    always @(posedge clk) begin
        if (!rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !o_full) begin
                decode_char(drv_char, drv_eot);
                void'(char_q.pop_front());
                n_chars++;
                tx_gap = pick_gap(tx_calm);
            end
            if (push && o_full) begin
                // hold the request until taken
            end else if (tx_gap > 0) begin
                tx_gap--;
                push <= 1'b0;
            end else if (char_q.size() != 0) begin
                push     <= 1'b1;
                drv_char <= char_q[0].ch;
                drv_eot  <= char_q[0].eot;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result receiver and checker
    always @(posedge clk) begin
        if (!rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !o_empty) begin
                n_results++;
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d with nothing expected", n_results));
                end else begin
                    want = decoded_q.pop_front();
                    check_field("data_byte", 16'(o_data_byte), 16'(want.data_byte));
                    check_field("byte_present", 16'(o_byte_present),
                                16'(want.byte_present));
                    check_field("run_end", 16'(o_run_end), 16'(want.run_end));
                    check_field("error_code", 16'(o_error_code), 16'(want.error_code));
                    check_field("byte_total", o_byte_total, want.byte_total);
                end
                rx_stall = pick_gap(rx_calm);
                if (n_results == 100 || n_results == 900) rx_stall = LONG_HOLD;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        int target;
        logic [LIMIT_W-1:0] lim;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_mode(1'b0, LIMIT_RESET);
        @(negedge clk);
        add_text("TWFu");
        add_text("TQ==");
        add_text("+/z0");
        add_text("A-C");
        add_text("A=B");
        add_char(8'h00, 1'b1);
        add_char(8'hFF, 1'b1);
        drain();

        set_mode(1'b1, LIMIT_RESET);
        @(negedge clk);
        add_text("-_w8");
        add_text("+");
        drain();

        set_mode(1'b0, '0);
        @(negedge clk);
        add_text("QQA");
        drain();

        target = n_queued;
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: lim = LIMIT_RESET;
                1: lim = '0;
                2: lim = 16'd1;
                3: lim = LIMIT_RESET;
                4: lim = 16'($urandom_range(2, 12));
                5: lim = 16'($urandom_range(0, 30));
                default: lim = LIMIT_RESET;
            endcase
            set_mode(p[0], lim);
            @(negedge clk);
            target += PHASE_CHARS;
            while (n_queued < target) add_message(url_sel);
            drain();
        end

        $display("checked %0d results from %0d characters over 10 register settings",
                 n_results, n_chars);
        $display("%0d messages closed: %0d on bad characters, %0d on overflow",
                 n_msgs, n_bad, n_ovf);
        if (n_errors == 0)
            $display("base64_stream_decoder regression: pass");
        else
            $display("base64_stream_decoder regression: fail");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timed out with %0d results outstanding", decoded_q.size());
        $display("base64_stream_decoder regression: fail");
        $finish;
    end

endmodule
